// ===== hdl/xmodem_checksum_sender_top_macros.svh =====
// assertion macros for the xmodem checksum sender checker
// used by xcs_checker only, no other dependencies
`ifndef XMODEM_CHECKSUM_SENDER_TOP_MACROS_SVH
`define XMODEM_CHECKSUM_SENDER_TOP_MACROS_SVH

// same-cycle implication
`define XCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xcs assertion failed");

// next-cycle implication
`define XCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xcs assertion failed");

`endif

// ===== hdl/xcs_pkg.sv =====
// shared types and constants of the xmodem checksum sender
// no dependencies
package xcs_pkg;

  localparam int unsigned BLOCK_BYTES = 128;

  localparam int unsigned ADDR_W = $clog2(BLOCK_BYTES);
  localparam int unsigned FILL_W = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned POS_W  = $clog2(BLOCK_BYTES + 4);

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BLOCK_BYTES);
  localparam logic [POS_W-1:0]  POS_DATA  = POS_W'(3);
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(BLOCK_BYTES + 3);

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_FILE  = 2'd1;
  localparam logic [1:0] CMD_REPLY = 2'd2;
  localparam logic [1:0] CMD_READY = 2'd3;

  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_STARTED = 3'd1;
  localparam logic [2:0] ST_REFUSED = 3'd2;
  localparam logic [2:0] ST_ABORTED = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;

  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;

  localparam logic       CFG_RETRY_LIMIT = 1'b0;
  localparam logic       CFG_START_CODE  = 1'b1;
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd2;
  localparam logic [7:0] START_CODE_RST  = 8'd51;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] file_byte;
    logic       file_end;
    logic [7:0] reply_byte;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] status;
    logic [7:0] block_number;
  } out_t;

endpackage

// ===== hdl/xcs_engine.sv =====
// sender state, block buffer and per-item result register
// depends on xcs_pkg
module xcs_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  input  logic          step_i,
  input  xcs_pkg::in_t  item_i,
  output xcs_pkg::out_t res_o
);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_WAIT_START = 3'd1;
  localparam logic [2:0] PH_FILL       = 3'd2;
  localparam logic [2:0] PH_SEND       = 3'd3;
  localparam logic [2:0] PH_WAIT_REPLY = 3'd4;
  localparam logic [2:0] PH_EOT_DONE   = 3'd5;
  localparam logic [2:0] PH_EOT_ABORT  = 3'd6;

  logic [3:0] retry_limit_q;
  logic [7:0] start_code_q;

  logic [2:0]                 phase_q, phase_d;
  logic [xcs_pkg::FILL_W-1:0] fill_q, fill_d, fill_inc;
  logic [7:0]                 sum_q, sum_d;
  logic [7:0]                 blk_q, blk_d;
  logic [3:0]                 resend_q, resend_d;
  logic [xcs_pkg::POS_W-1:0]  pos_q, pos_d, idx;
  logic                       final_q, final_d;

  logic [7:0] mem_q [xcs_pkg::BLOCK_BYTES];
  logic [7:0] rd_data_q;
  logic       wr_en;
  logic       use_mem, use_mem_q;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [2:0] status;
  xcs_pkg::out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= xcs_pkg::RETRY_LIMIT_RST;
      start_code_q  <= xcs_pkg::START_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        xcs_pkg::CFG_RETRY_LIMIT: retry_limit_q <= cfg_data_i[3:0];
        xcs_pkg::CFG_START_CODE:  start_code_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign fill_inc = fill_q + xcs_pkg::FILL_W'(1);
  assign idx      = pos_q - xcs_pkg::POS_DATA;

  always_comb begin
    phase_d  = phase_q;
    fill_d   = fill_q;
    sum_d    = sum_q;
    blk_d    = blk_q;
    resend_d = resend_q;
    pos_d    = pos_q;
    final_d  = final_q;
    wr_en    = 1'b0;
    use_mem  = 1'b0;
    tx_valid = 1'b0;
    tx_byte  = 8'd0;
    status   = xcs_pkg::ST_IGNORED;
    case (item_i.cmd)
      xcs_pkg::CMD_BEGIN: begin
        fill_d   = '0;
        sum_d    = 8'd0;
        pos_d    = '0;
        blk_d    = 8'd1;
        resend_d = 4'd0;
        final_d  = 1'b0;
        phase_d  = PH_WAIT_START;
        tx_valid = 1'b1;
        tx_byte  = start_code_q;
        status   = xcs_pkg::ST_BUSY;
      end
      xcs_pkg::CMD_FILE: begin
        if (phase_q == PH_FILL && fill_q < xcs_pkg::FILL_FULL) begin
          wr_en  = 1'b1;
          fill_d = fill_inc;
          sum_d  = sum_q + item_i.file_byte;
          if (fill_inc == xcs_pkg::FILL_FULL || item_i.file_end) begin
            final_d = item_i.file_end;
            pos_d   = '0;
            phase_d = PH_SEND;
          end
          status = xcs_pkg::ST_BUSY;
        end
      end
      xcs_pkg::CMD_REPLY: begin
        if (phase_q == PH_WAIT_START) begin
          if (item_i.reply_byte == xcs_pkg::BYTE_NAK) begin
            phase_d = PH_FILL;
            status  = xcs_pkg::ST_STARTED;
          end else begin
            phase_d = PH_IDLE;
            status  = xcs_pkg::ST_REFUSED;
          end
        end else if (phase_q == PH_WAIT_REPLY) begin
          if (item_i.reply_byte == xcs_pkg::BYTE_NAK) begin
            if (resend_q < retry_limit_q) begin
              resend_d = resend_q + 4'd1;
              pos_d    = '0;
              phase_d  = PH_SEND;
              status   = xcs_pkg::ST_BUSY;
            end else begin
              phase_d = PH_EOT_ABORT;
              status  = xcs_pkg::ST_ABORTED;
            end
          end else begin
            resend_d = 4'd0;
            blk_d    = blk_q + 8'd1;
            if (final_q) begin
              phase_d = PH_EOT_DONE;
            end else begin
              fill_d  = '0;
              sum_d   = 8'd0;
              pos_d   = '0;
              phase_d = PH_FILL;
            end
            status = xcs_pkg::ST_BUSY;
          end
        end
      end
      xcs_pkg::CMD_READY: begin
        if (phase_q == PH_SEND) begin
          tx_valid = 1'b1;
          status   = xcs_pkg::ST_BUSY;
          if (pos_q == xcs_pkg::POS_W'(0)) begin
            tx_byte = xcs_pkg::BYTE_SOH;
          end else if (pos_q == xcs_pkg::POS_W'(1)) begin
            tx_byte = blk_q;
          end else if (pos_q == xcs_pkg::POS_W'(2)) begin
            tx_byte = ~blk_q;
          end else if (pos_q < xcs_pkg::POS_LAST) begin
            use_mem = idx < xcs_pkg::POS_W'(fill_q);
          end else begin
            tx_byte = sum_q;
          end
          if (pos_q >= xcs_pkg::POS_LAST) begin
            phase_d = PH_WAIT_REPLY;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + xcs_pkg::POS_W'(1);
          end
        end else if (phase_q == PH_EOT_DONE || phase_q == PH_EOT_ABORT) begin
          tx_valid = 1'b1;
          tx_byte  = xcs_pkg::BYTE_EOT;
          status   = (phase_q == PH_EOT_ABORT) ? xcs_pkg::ST_ABORTED : xcs_pkg::ST_DONE;
          phase_d  = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      fill_q    <= '0;
      sum_q     <= 8'd0;
      blk_q     <= 8'd1;
      resend_q  <= 4'd0;
      pos_q     <= '0;
      final_q   <= 1'b0;
      use_mem_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      fill_q    <= fill_d;
      sum_q     <= sum_d;
      blk_q     <= blk_d;
      resend_q  <= resend_d;
      pos_q     <= pos_d;
      final_q   <= final_d;
      use_mem_q <= use_mem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      rd_data_q <= mem_q[idx[xcs_pkg::ADDR_W-1:0]];
      if (wr_en) begin
        mem_q[fill_q[xcs_pkg::ADDR_W-1:0]] <= item_i.file_byte;
      end
      res_q.tx_valid     <= tx_valid;
      res_q.tx_byte      <= tx_byte;
      res_q.status       <= status;
      res_q.block_number <= blk_d;
    end
  end

  always_comb begin
    res_o = res_q;
    if (use_mem_q) begin
      res_o.tx_byte = rd_data_q;
    end
  end

endmodule

// ===== hdl/xmodem_checksum_sender_top.sv =====
// xmodem checksum sender top level: handshake registers around xcs_engine
// depends on xcs_pkg and xcs_engine
//
// One result per input transfer. An accepted item sits in the input register,
// is processed from there while the block buffer is read, and its result
// appears in the output register. One item per cycle is sustained when the
// output side does not stall. The 128-byte block buffer has one write and one
// registered read port, so the data byte of a frame arrives together with the
// rest of its result.
// Configuration writes are taken at any cycle with cfg_we_i high and must be
// made while the block is idle.
module xmodem_checksum_sender_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  xcs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output xcs_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  logic         in_valid_q, in_valid_d;
  xcs_pkg::in_t in_q;
  logic         out_valid_q, out_valid_d;
  logic         step;
  logic         in_accept;

  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept || (in_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  xcs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .item_i      (in_q),
    .res_o       (out_data_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/xcs_checker.sv =====
// port-level checks for the xmodem checksum sender
// depends on xcs_pkg and xmodem_checksum_sender_top_macros.svh, bound to the top
`include "xmodem_checksum_sender_top_macros.svh"

module xcs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input xcs_pkg::out_t out_data_o
);

  logic out_held;
  logic quiet_res;
  logic done_res;
  logic eot_sent;
  logic send_res;
  logic send_status_ok;

  assign out_held       = out_valid_o && out_stall_i;
  assign quiet_res      = out_valid_o && !out_data_o.tx_valid;
  assign done_res       = out_valid_o && (out_data_o.status == xcs_pkg::ST_DONE);
  assign eot_sent       = out_data_o.tx_valid && (out_data_o.tx_byte == xcs_pkg::BYTE_EOT);
  assign send_res       = out_valid_o && out_data_o.tx_valid;
  assign send_status_ok = (out_data_o.status == xcs_pkg::ST_BUSY) ||
                          (out_data_o.status == xcs_pkg::ST_ABORTED) ||
                          (out_data_o.status == xcs_pkg::ST_DONE);

  `XCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_data_o))
  `XCS_ASSERT_IMPL(a_stall_only_backpressure, clk_i, rst_ni, in_stall_o, out_held)
  `XCS_ASSERT_IMPL(a_quiet_byte_zero, clk_i, rst_ni, quiet_res, out_data_o.tx_byte == 8'd0)
  `XCS_ASSERT_IMPL(a_done_is_eot, clk_i, rst_ni, done_res, eot_sent)
  `XCS_ASSERT_IMPL(a_send_status, clk_i, rst_ni, send_res, send_status_ok)

endmodule

bind xmodem_checksum_sender_top xcs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
